// ----- hdl/vlfc_pkg.sv -----
// Shared types and constants for the varint layer framing check.
// No dependencies; imported by vlfc_framer and varint_layer_framing_check_top.
package vlfc_pkg;

  localparam int unsigned DATA_W     = 8;
  localparam int unsigned ACC_W      = 64;
  localparam int unsigned GROUP_W    = 7;
  localparam int unsigned COUNT_W    = 4;
  localparam int unsigned MAX_GROUPS = 10;

  localparam logic [1:0] PH_LEN  = 2'd0;
  localparam logic [1:0] PH_TAG  = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;
  localparam logic [1:0] PH_FAIL = 2'd3;

  localparam logic [DATA_W-1:0] TAG_A     = 8'h01;
  localparam logic [DATA_W-1:0] TAG_B     = 8'h02;
  localparam logic [DATA_W-1:0] GROUP_MSK = 8'h7f;
  localparam logic [DATA_W-1:0] CONT_MSK  = 8'h80;

  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic              last_byte;
  } item_t;

endpackage

// ----- hdl/varint_layer_framing_check_top.sv -----
// A final beat passes the input register, then its verdict waits in the output register.
// Throughput: one input beat per cycle while no final beat waits on an untaken verdict.
// Only a final beat yields an output; other beats advance even while a verdict waits.
// Reset (rst, synchronous, active high) empties both registers and clears framing state.
// Top level: input register, vlfc_framer, verdict output register. Depends on vlfc_pkg.
module varint_layer_framing_check_top
  import vlfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,  // [7:0] data_byte
  input  logic       s_tlast,  // last_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata   // [0] is_tile, [7:1] zero
);

  logic  in_valid;
  item_t in_item;
  logic  in_advance;
  logic  verdict;
  logic  is_tile;

  assign in_advance = in_valid && (!in_item.last_byte || !m_tvalid || m_tready);
  assign s_tready   = !in_valid || in_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.data_byte <= s_tdata;
      in_item.last_byte <= s_tlast;
    end
  end

  vlfc_framer u_framer (
    .clk     (clk),
    .rst     (rst),
    .step    (in_advance),
    .item    (in_item),
    .verdict (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      m_tvalid <= (m_tvalid && !m_tready) || (in_advance && in_item.last_byte);
    end
  end

  always_ff @(posedge clk) begin
    if (in_advance && in_item.last_byte) begin
      is_tile <= verdict;
    end
  end

  assign m_tdata = {7'd0, is_tile};

`ifndef SYNTH
  assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && in_item.last_byte && m_tvalid))
    else $error("input stalled without a waiting verdict");

  assert property (@(posedge clk) disable iff (rst)
    (in_advance && in_item.last_byte) |=> m_tvalid)
    else $error("final beat produced no verdict");

  assert property (@(posedge clk) disable iff (rst)
    (in_advance && !in_item.last_byte && !(m_tvalid && !m_tready)) |=> !m_tvalid)
    else $error("verdict emitted for a non-final beat");
`endif

endmodule

// ----- hdl/vlfc_framer.sv -----
// Record framing state: LEB128 length assembly, tag check, body countdown.
// Depends on vlfc_pkg; instantiated by varint_layer_framing_check_top.
module vlfc_framer
  import vlfc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  step,
  input  item_t item,
  output logic  verdict
);

  logic [1:0]         phase, phase_next;
  logic [ACC_W-1:0]   length_accum, length_accum_next;
  logic [COUNT_W-1:0] group_count, group_count_next;
  logic [ACC_W-1:0]   body_remaining, body_remaining_next;
  logic               seen_record, seen_record_next;

  logic [6:0]         shift_wide;
  logic [ACC_W-1:0]   group_bits;
  logic [ACC_W-1:0]   acc_or;
  logic [ACC_W-1:0]   body_dec;
  logic [DATA_W-1:0]  b;

  assign b          = item.data_byte;
  assign shift_wide = 7'(group_count) * 7'(GROUP_W);
  assign group_bits = {{(ACC_W-DATA_W){1'b0}}, (b & GROUP_MSK)} << shift_wide[5:0];
  assign acc_or     = length_accum | group_bits;
  assign body_dec   = body_remaining - 64'd1;

  always_comb begin
    phase_next          = phase;
    length_accum_next   = length_accum;
    group_count_next    = group_count;
    body_remaining_next = body_remaining;
    seen_record_next    = seen_record;
    case (phase)
      PH_LEN: begin
        if (group_count >= COUNT_W'(MAX_GROUPS)) begin
          phase_next = PH_FAIL;
        end else begin
          length_accum_next = acc_or;
          group_count_next  = group_count + 4'd1;
          if ((b & CONT_MSK) == '0) begin
            if (acc_or == '0) begin
              phase_next = PH_FAIL;
            end else begin
              body_remaining_next = acc_or;
              length_accum_next   = '0;
              group_count_next    = '0;
              phase_next          = PH_TAG;
            end
          end
        end
      end
      PH_TAG: begin
        if (b != TAG_A && b != TAG_B) begin
          phase_next = PH_FAIL;
        end else begin
          body_remaining_next = body_dec;
          if (body_dec == '0) begin
            seen_record_next = 1'b1;
            phase_next       = PH_LEN;
          end else begin
            phase_next = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        body_remaining_next = body_dec;
        if (body_dec == '0) begin
          seen_record_next = 1'b1;
          phase_next       = PH_LEN;
        end
      end
      default: begin
        phase_next = PH_FAIL;
      end
    endcase
  end

  assign verdict = (phase_next == PH_LEN) && (group_count_next == '0) && seen_record_next;

  always_ff @(posedge clk) begin
    if (rst || (step && item.last_byte)) begin
      phase          <= PH_LEN;
      length_accum   <= '0;
      group_count    <= '0;
      body_remaining <= '0;
      seen_record    <= 1'b0;
    end else if (step) begin
      phase          <= phase_next;
      length_accum   <= length_accum_next;
      group_count    <= group_count_next;
      body_remaining <= body_remaining_next;
      seen_record    <= seen_record_next;
    end
  end

`ifndef SYNTH
  assert property (@(posedge clk) disable iff (rst)
    group_count <= COUNT_W'(MAX_GROUPS))
    else $error("length group count overran");

  assert property (@(posedge clk) disable iff (rst)
    (phase == PH_TAG || phase == PH_BODY) |-> body_remaining != '0)
    else $error("body phase with nothing left to read");

  assert property (@(posedge clk) disable iff (rst)
    (step && item.last_byte) |=> (phase == PH_LEN && group_count == '0 && !seen_record))
    else $error("state not cleared after final byte");
`endif

endmodule

// ----- dv/varint_layer_framing_check_tb.sv -----
// Testbench for varint_layer_framing_check_top: directed and random byte buffers.
// Predicts each buffer verdict internally and checks every output beat.
// Depends on vlfc_pkg and the top-level RTL.
module testbench;
  import vlfc_pkg::*;

  typedef logic [7:0] byte_q_t[$];
  typedef enum int {CUT_SHORT, FLIP_BYTE, LONG_LENGTH, NOISE, ZERO_LENGTH} fault_e;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;

  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  bit tile_verdicts[$];

  logic [1:0]  frm_phase = PH_LEN;
  logic [63:0] frm_len = '0;
  logic [3:0]  frm_groups = '0;
  logic [63:0] frm_body_left = '0;
  logic        frm_seen = 1'b0;

  varint_layer_framing_check_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic void frm_clear();
    frm_phase = PH_LEN;
    frm_len = '0;
    frm_groups = '0;
    frm_body_left = '0;
    frm_seen = 1'b0;
  endfunction

  function automatic void frm_body_byte();
    frm_body_left = frm_body_left - 64'd1;
    if (frm_body_left == 64'd0) begin
      frm_seen = 1'b1;
      frm_phase = PH_LEN;
    end else begin
      frm_phase = PH_BODY;
    end
  endfunction

  function automatic void predict_beat(input logic [7:0] b, input logic fin);
    bit ok;
    case (frm_phase)
      PH_LEN: begin
        if (frm_groups >= MAX_GROUPS) begin
          frm_phase = PH_FAIL;
        end else begin
          frm_len = frm_len | ({56'd0, b & GROUP_MSK} << (GROUP_W * frm_groups));
          frm_groups = frm_groups + 4'd1;
          if ((b & CONT_MSK) == 8'd0) begin
            if (frm_len == 64'd0) begin
              frm_phase = PH_FAIL;
            end else begin
              frm_body_left = frm_len;
              frm_len = '0;
              frm_groups = '0;
              frm_phase = PH_TAG;
            end
          end
        end
      end
      PH_TAG: begin
        if (b != TAG_A && b != TAG_B) begin
          frm_phase = PH_FAIL;
        end else begin
          frm_body_byte();
        end
      end
      PH_BODY: begin
        frm_body_byte();
      end
      default: begin
      end
    endcase
    if (fin) begin
      ok = (frm_phase == PH_LEN && frm_groups == 4'd0 && frm_seen);
      tile_verdicts = {tile_verdicts, ok};
      frm_clear();
    end
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  task automatic send_beat(input logic [7:0] b, input logic fin);
    logic took;
    while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= fin;
    do begin
      @(negedge clk);
      took = s_tready;
      @(posedge clk);
    end while (!took);
    predict_beat(b, fin);
  endtask

  task automatic send_frame(input byte_q_t fb);
    for (int i = 0; i < fb.size(); i++) begin
      send_beat(fb[i], i == fb.size() - 1);
    end
  endtask

  function automatic void add_byte(ref byte_q_t fb, input logic [7:0] v);
    fb = {fb, v};
  endfunction

  function automatic void push_record(ref byte_q_t fb, input int unsigned len,
                                      input bit padded);
    int unsigned rest;
    rest = len;
    while (rest >= 128) begin
      add_byte(fb, {1'b1, rest[6:0]});
      rest = rest >> 7;
    end
    if (padded) begin
      add_byte(fb, {1'b1, rest[6:0]});
      add_byte(fb, 8'h00);
    end else begin
      add_byte(fb, {1'b0, rest[6:0]});
    end
    add_byte(fb, $urandom_range(1) ? TAG_B : TAG_A);
    for (int unsigned i = 1; i < len; i++) begin
      add_byte(fb, 8'($urandom));
    end
  endfunction

  task automatic test_directed_framing();
    byte_q_t fb;
    fb = {8'h01, TAG_A};
    send_frame(fb);
    fb = {8'h02, TAG_B, 8'h00, 8'h01, TAG_A};
    send_frame(fb);
    fb = {8'h01, 8'hff};
    send_frame(fb);
    fb = {8'h00};
    send_frame(fb);
    fb = {8'h81};
    send_frame(fb);
    fb = {8'h02, TAG_A};
    send_frame(fb);
    // tenth group keeps only bit 0, so this length collapses to zero
    fb = {};
    repeat (9) add_byte(fb, CONT_MSK);
    add_byte(fb, 8'h02);
    send_frame(fb);
  endtask

  task automatic test_random_buffers(input int gap_pct, input int stall_pct,
                                     input int n_items);
    byte_q_t fb;
    int      sent;
    int      nrec;
    int      len;
    fault_e  fault;
    send_gap_pct = gap_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      fb = {};
      nrec = $urandom_range(4, 1);
      for (int r = 0; r < nrec; r++) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(300, 100) : $urandom_range(12, 1);
        push_record(fb, len, $urandom_range(4) == 0);
      end
      if ($urandom_range(99) >= 75) begin
        fault = fault_e'($urandom_range(4));
        case (fault)
          CUT_SHORT: begin
            len = $urandom_range(fb.size() - 1, 1);
            while (fb.size() > len) void'(fb.pop_back());
          end
          FLIP_BYTE: begin
            fb[$urandom_range(fb.size() - 1)] = 8'($urandom);
          end
          LONG_LENGTH: begin
            fb = {};
            repeat ($urandom_range(11, 9)) add_byte(fb, CONT_MSK | 8'($urandom_range(127)));
            add_byte(fb, 8'($urandom));
            push_record(fb, $urandom_range(4, 1), 1'b0);
          end
          NOISE: begin
            fb = {};
            repeat ($urandom_range(20, 1)) add_byte(fb, 8'($urandom));
          end
          ZERO_LENGTH: begin
            add_byte(fb, 8'h00);
            push_record(fb, $urandom_range(4, 1), 1'b0);
          end
          default: begin
          end
        endcase
      end
      send_frame(fb);
      sent += fb.size();
    end
  endtask

  initial begin : verdict_monitor
    logic       hs;
    logic [7:0] beat;
    bit         want_tile;
    forever begin
      @(negedge clk);
      hs = m_tvalid && m_tready && !rst;
      beat = m_tdata;
      @(posedge clk);
      if (hs) begin
        if (tile_verdicts.size() == 0) begin
          report_mismatch($sformatf("verdict beat %02h with none pending", beat));
        end else begin
          want_tile = tile_verdicts.pop_front();
          if (beat[0] !== want_tile) begin
            report_mismatch($sformatf("is_tile %b, predicted %b", beat[0], want_tile));
          end
          if (beat[7:1] !== 7'd0) begin
            report_mismatch($sformatf("pad bits %b not zero", beat[7:1]));
          end
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int drain;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_framing();
    test_random_buffers(0, 0, 310);
    test_random_buffers(50, 0, 310);
    test_random_buffers(0, 50, 310);
    test_random_buffers(25, 25, 310);
    s_tvalid <= 1'b0;
    drain = 0;
    while (tile_verdicts.size() != 0 && drain < 1000) begin
      @(posedge clk);
      drain++;
    end
    repeat (4) @(posedge clk);
    if (tile_verdicts.size() != 0) begin
      report_mismatch($sformatf("%0d verdicts never arrived", tile_verdicts.size()));
    end
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
